// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the sentence slot capture block.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define NSSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define NSSC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define NSSC_ASSERT(label, clk, rst_n, prop, msg)
`define NSSC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/nssc_pkg.sv -----
// Types and constants of the sentence slot capture block.
// No dependencies; used by the stream interface and the capture module.
`timescale 1ns / 1ps
package nssc_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_READ    = 2'd2
    } t_cmd;

    localparam logic [7:0]  CH_DOLLAR = 8'h24;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam logic [23:0] TAG_VTG   = 24'h565447;
    localparam logic [23:0] TAG_GGA   = 24'h474741;

    // Type letters sit at positions 3 to 5; shorter sentences never match.
    localparam int TAG_POS_FIRST = 3;
    localparam int TAG_POS_LAST  = 5;
    localparam int MIN_TAG_LEN   = 6;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [1:0] read_slot;
        logic [6:0] read_offset;
    } t_in_item;

    typedef struct packed {
        logic       vtg_held;
        logic [1:0] vtg_slot_out;
        logic       gga_held;
        logic [1:0] gga_slot_out;
        logic       gga_marked;
        logic [7:0] read_data;
    } t_out_item;

    // Status part of a result, held while the store read completes.
    typedef struct packed {
        logic       vtg_held;
        logic [1:0] vtg_slot_out;
        logic       gga_held;
        logic [1:0] gga_slot_out;
        logic       gga_marked;
        logic       rd_hit;
    } t_status;

endpackage

// ----- rtl/nssc_stream_if.sv -----
// Valid/ready stream channel carrying one payload per request.
// Depends on nssc_pkg for the payload types it is given.
`timescale 1ns / 1ps
interface nssc_stream_if #(
    parameter type t_payload = nssc_pkg::t_in_item
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/nssc_store_ram.sv -----
// Byte store for the sentence slots: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module nssc_store_ram #(
    parameter int DEPTH  = 240,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read word until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/nmea_sentence_slot_capture.sv -----
// Sentence slot capture: files received bytes into slots and tags VTG/GGA.
// A result is valid in the cycle after its request is accepted.
// Takes one request per cycle unless o_rsp stalls; one store write or read.
// Reset (sync, active low) clears the capture state and both tags; the
// byte store keeps its contents and needs no clearing pass.
// Depends on nssc_pkg, nssc_stream_if, nssc_store_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nmea_sentence_slot_capture #(
    parameter int SLOT_LENGTH = 80,
    parameter int SLOT_COUNT  = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nssc_stream_if.sink   i_req,
    nssc_stream_if.source o_rsp
);

    localparam int DEPTH  = SLOT_COUNT * SLOT_LENGTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(SLOT_LENGTH);
    localparam int SIDX_W = $clog2(SLOT_COUNT);

    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(SLOT_LENGTH - 1);
    localparam logic [POS_W-1:0]  TAG_FIRST = POS_W'(nssc_pkg::TAG_POS_FIRST);
    localparam logic [POS_W-1:0]  TAG_LAST  = POS_W'(nssc_pkg::TAG_POS_LAST);
    localparam logic [POS_W-1:0]  MIN_LEN   = POS_W'(nssc_pkg::MIN_TAG_LEN);
    localparam logic [ADDR_W-1:0] LEN_A     = ADDR_W'(SLOT_LENGTH);

    // Capture and tag state
    logic              r_act_vld,  n_act_vld;
    logic [SIDX_W-1:0] r_act_slot, n_act_slot;
    logic [POS_W-1:0]  r_wpos,     n_wpos;
    logic [23:0]       r_tl,       n_tl;
    logic              r_vtg_vld,  n_vtg_vld;
    logic [SIDX_W-1:0] r_vtg_slot, n_vtg_slot;
    logic              r_gga_vld,  n_gga_vld;
    logic [SIDX_W-1:0] r_gga_slot, n_gga_slot;

    // Result stage
    logic                r_s1_vld;
    nssc_pkg::t_status   r_s1;
    nssc_pkg::t_status   n_s1;

    logic              w_acc;
    logic              w_byte;
    logic              w_dollar;
    logic              w_cr;
    logic              w_free_vld;
    logic [SIDX_W-1:0] w_free_slot;
    logic              c_act_vld;
    logic [SIDX_W-1:0] c_act_slot;
    logic [POS_W-1:0]  c_wpos;
    logic [23:0]       c_tl;
    logic              w_long;
    logic              w_marked;
    logic              w_rd_ok;
    logic              w_re;
    logic              w_we;
    logic [7:0]        w_wdata;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_rdata;

    // Accept whenever the result register is empty or being drained.
    assign i_req.ready = !r_s1_vld || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_byte      = w_acc && (i_req.data.command == nssc_pkg::CMD_BYTE);
    assign w_dollar    = (i_req.data.rx_byte == nssc_pkg::CH_DOLLAR);
    assign w_cr        = (i_req.data.rx_byte == nssc_pkg::CH_CR);

    // Lowest slot that neither tag holds.
    always_comb begin
        w_free_vld  = 1'b0;
        w_free_slot = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!((r_vtg_vld && r_vtg_slot == SIDX_W'(s)) ||
                  (r_gga_vld && r_gga_slot == SIDX_W'(s)))) begin
                w_free_vld  = 1'b1;
                w_free_slot = SIDX_W'(s);
            end
        end
    end

    // A '$' restarts capture in the free slot before the byte is stored.
    assign c_act_vld  = w_dollar ? w_free_vld  : r_act_vld;
    assign c_act_slot = w_dollar ? w_free_slot : r_act_slot;
    assign c_wpos     = w_dollar ? '0 : r_wpos;
    assign c_tl       = w_dollar ? '0 : r_tl;
    assign w_long     = (c_wpos >= MIN_LEN);

    assign w_waddr = ADDR_W'(c_act_slot) * LEN_A + ADDR_W'(c_wpos);
    assign w_wdata = w_cr ? nssc_pkg::CH_NUL : i_req.data.rx_byte;
    // Drop bytes past the last position; the terminator always fits.
    assign w_we    = w_byte && c_act_vld && (w_cr || (c_wpos < LAST_POS));

    assign w_rd_ok = (32'(i_req.data.read_slot) < SLOT_COUNT) &&
                     (32'(i_req.data.read_offset) < SLOT_LENGTH);
    assign w_re    = w_acc && (i_req.data.command == nssc_pkg::CMD_READ) && w_rd_ok;
    assign w_raddr = ADDR_W'(i_req.data.read_slot) * LEN_A +
                     ADDR_W'(i_req.data.read_offset);

    // Next capture and tag state
    always_comb begin
        n_act_vld  = r_act_vld;
        n_act_slot = r_act_slot;
        n_wpos     = r_wpos;
        n_tl       = r_tl;
        n_vtg_vld  = r_vtg_vld;
        n_vtg_slot = r_vtg_slot;
        n_gga_vld  = r_gga_vld;
        n_gga_slot = r_gga_slot;
        w_marked   = 1'b0;
        if (w_byte) begin
            n_act_vld  = c_act_vld;
            n_act_slot = c_act_slot;
            n_wpos     = c_wpos;
            n_tl       = c_tl;
            if (c_act_vld) begin
                if (w_cr) begin
                    n_act_vld = 1'b0;
                    if (w_long && !r_vtg_vld && c_tl == nssc_pkg::TAG_VTG) begin
                        n_vtg_vld  = 1'b1;
                        n_vtg_slot = c_act_slot;
                    end else if (w_long && !r_gga_vld && c_tl == nssc_pkg::TAG_GGA) begin
                        n_gga_vld  = 1'b1;
                        n_gga_slot = c_act_slot;
                        w_marked   = 1'b1;
                    end
                end else if (c_wpos < LAST_POS) begin
                    if (c_wpos >= TAG_FIRST && c_wpos <= TAG_LAST) begin
                        n_tl = {c_tl[15:0], i_req.data.rx_byte};
                    end
                    n_wpos = c_wpos + 1'b1;
                end
            end
        end else if (w_acc && i_req.data.command == nssc_pkg::CMD_RELEASE) begin
            n_vtg_vld = 1'b0;
            n_gga_vld = 1'b0;
        end
    end

    // Status after this request
    always_comb begin
        n_s1.vtg_held     = n_vtg_vld;
        n_s1.vtg_slot_out = n_vtg_vld ? 2'(n_vtg_slot) : 2'd0;
        n_s1.gga_held     = n_gga_vld;
        n_s1.gga_slot_out = n_gga_vld ? 2'(n_gga_slot) : 2'd0;
        n_s1.gga_marked   = w_marked;
        n_s1.rd_hit       = w_re;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_vld  <= 1'b0;
            r_act_slot <= '0;
            r_wpos     <= '0;
            r_tl       <= '0;
            r_vtg_vld  <= 1'b0;
            r_vtg_slot <= '0;
            r_gga_vld  <= 1'b0;
            r_gga_slot <= '0;
        end else if (w_acc) begin
            r_act_vld  <= n_act_vld;
            r_act_slot <= n_act_slot;
            r_wpos     <= n_wpos;
            r_tl       <= n_tl;
            r_vtg_vld  <= n_vtg_vld;
            r_vtg_slot <= n_vtg_slot;
            r_gga_vld  <= n_gga_vld;
            r_gga_slot <= n_gga_slot;
        end
    end

    // Result register: load on accept, drop when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_acc) begin
            r_s1_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= n_s1;
        end
    end

    // Read data lands in the cycle after the request, aligned with r_s1.
    nssc_store_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_rsp.valid             = r_s1_vld;
    assign o_rsp.data.vtg_held     = r_s1.vtg_held;
    assign o_rsp.data.vtg_slot_out = r_s1.vtg_slot_out;
    assign o_rsp.data.gga_held     = r_s1.gga_held;
    assign o_rsp.data.gga_slot_out = r_s1.gga_slot_out;
    assign o_rsp.data.gga_marked   = r_s1.gga_marked;
    assign o_rsp.data.read_data    = r_s1.rd_hit ? w_rdata : 8'h00;

    `NSSC_ASSERT_NEVER(a_tags_distinct, i_clk, i_rst_n, r_vtg_vld && r_gga_vld && r_vtg_slot == r_gga_slot, "both tags hold one slot")
    `NSSC_ASSERT_NEVER(a_active_not_held, i_clk, i_rst_n, r_act_vld && ((r_vtg_vld && r_vtg_slot == r_act_slot) || (r_gga_vld && r_gga_slot == r_act_slot)), "capture runs in a held slot")
    `NSSC_ASSERT(a_wpos_range, i_clk, i_rst_n, r_wpos <= LAST_POS, "write position past slot end")
    `NSSC_ASSERT(a_rd_only_on_read, i_clk, i_rst_n, (w_acc && i_req.data.command != nssc_pkg::CMD_READ) |=> (r_s1_vld && !r_s1.rd_hit), "read data flagged for a non-read")
    `NSSC_ASSERT(a_mark_tags, i_clk, i_rst_n, (w_acc && w_marked) |=> (r_gga_vld && r_s1.gga_held), "marked sentence not held")

endmodule
